// File: hw/rtl/soft_viterbi_decoder_defines.svh
// assertion macros for the soft viterbi decoder checker
`ifndef SOFT_VITERBI_DECODER_DEFINES_SVH
`define SOFT_VITERBI_DECODER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define SVD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("soft viterbi decoder check failed");

// next-cycle implication
`define SVD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("soft viterbi decoder check failed");

`endif

// File: hw/rtl/svd_pkg.sv
// shared constants and control types of the soft viterbi decoder
`default_nettype none
package svd_pkg;
  localparam int unsigned MaxConstraintDef = 7;
  localparam int unsigned MaxRate          = 4;
  localparam int unsigned MaxDepthDef      = 64;
  localparam int unsigned LlrWidthDef      = 8;
  localparam int unsigned MetricWidthDef   = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CfgConstraint = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRate       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPolyA      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPolyB      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPolyC      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPolyD      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgInvert     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgDepth      = 3'd7;

  localparam logic CmdDecode  = 1'b0;
  localparam logic CmdRestart = 1'b1;

  typedef struct packed {
    logic restart;
    logic load;
    logic acs_step;
    logic commit;
    logic tb_step;
    logic emit;
  } svd_cmd_t;

  typedef struct packed {
    logic acs_last;
    logic tb_last;
    logic full_next;
    logic depth_one;
    logic out_free;
  } svd_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/svd_dp.sv
// datapath: config registers, serial acs, metric and decision memories, traceback
`default_nettype none
module svd_dp #(
  parameter int unsigned MAX_CONSTRAINT = 7,
  parameter int unsigned MAX_DEPTH      = 64,
  parameter int unsigned LLR_WIDTH      = 8,
  parameter int unsigned METRIC_WIDTH   = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  svd_pkg::svd_cmd_t            cmd_i,
  output svd_pkg::svd_sts_t            sts_o,
  input  wire                          cfg_we_i,
  input  wire [svd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [svd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire [4*LLR_WIDTH-1:0]        llr_i,
  input  wire                          m_tready_i,
  output logic                         m_tvalid_o,
  output logic                         bit_o
);
  import svd_pkg::*;

  localparam int unsigned SW = MAX_CONSTRAINT - 1;
  localparam int unsigned NS = 1 << SW;
  localparam int unsigned DW = $clog2(MAX_DEPTH);
  localparam int unsigned FW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned LW = LLR_WIDTH;
  localparam int unsigned XW = ((METRIC_WIDTH > LW + 4) ? METRIC_WIDTH : LW + 4) + 3;
  localparam int unsigned RW = (MAX_CONSTRAINT > 7) ? MAX_CONSTRAINT : 7;
  localparam int unsigned NTop = (MaxRate < 4) ? MaxRate : 4;
  localparam logic signed [XW-1:0] Floor =
    {{(XW - METRIC_WIDTH + 2){1'b1}}, {(METRIC_WIDTH - 2){1'b0}}};

  // configuration
  logic [2:0] k_q, n_q;
  logic [6:0] poly_q [4];
  logic [3:0] inv_q;
  logic [6:0] dep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= 3'd7;
      n_q       <= 3'd2;
      poly_q[0] <= 7'd121;
      poly_q[1] <= 7'd91;
      poly_q[2] <= 7'd0;
      poly_q[3] <= 7'd0;
      inv_q     <= 4'd0;
      dep_q     <= 7'd60;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgConstraint: k_q       <= cfg_data_i[2:0];
        CfgRate:       n_q       <= cfg_data_i[2:0];
        CfgPolyA:      poly_q[0] <= cfg_data_i;
        CfgPolyB:      poly_q[1] <= cfg_data_i;
        CfgPolyC:      poly_q[2] <= cfg_data_i;
        CfgPolyD:      poly_q[3] <= cfg_data_i;
        CfgInvert:     inv_q     <= cfg_data_i[3:0];
        CfgDepth:      dep_q     <= cfg_data_i;
        default:       k_q       <= k_q;
      endcase
    end
  end

  logic [3:0]    ke;
  logic [2:0]    ne;
  logic [FW-1:0] de;
  logic [SW-1:0] mask;
  logic [3:0]    bsh;

  always_comb begin
    if (k_q < 3'd3) ke = 4'd3;
    else if ({1'b0, k_q} > 4'(MAX_CONSTRAINT)) ke = 4'(MAX_CONSTRAINT);
    else ke = {1'b0, k_q};
    if (n_q == 3'd0) ne = 3'd1;
    else if (n_q > 3'(NTop)) ne = 3'(NTop);
    else ne = n_q;
    if (dep_q == 7'd0) de = FW'(1);
    else if (int'(dep_q) > int'(MAX_DEPTH)) de = FW'(MAX_DEPTH);
    else de = FW'(dep_q);
    for (int i = 0; i < SW; i++) mask[i] = (4'(i) < ke - 4'd1);
    bsh = ke - 4'd2;
  end

  // step state
  logic                 prior_q, bank_q;
  logic [DW-1:0]        head_q, idx_q;
  logic [FW-1:0]        fill_q, tcnt_q;
  logic [SW-1:0]        ns_q;
  logic signed [XW-1:0] llr_q [4];
  logic signed [XW-1:0] best_q, bestn_q;
  logic [SW-1:0]        barg_q, st_q;
  logic [NS-1:0]        row_q, rrow_q;
  logic                 rv_q, outv_q, outb_q;

  logic [XW-1:0] pm_mem [2*NS];
  logic [NS-1:0] ring_mem [MAX_DEPTH];

  // acs pipeline
  logic                 va_q, vb_q;
  logic [SW-1:0]        nsa_q, nsb_q;
  logic signed [XW-1:0] rd0_q, rd1_q, mb_q;
  logic                 tbit_q;

  logic [SW-1:0] p0i, p0a, p0s;
  logic [DW-1:0] head_n, idx_n;
  logic signed [XW-1:0] eff0, eff1, d0, d1, bm0, bm1, m0, m1;
  logic [RW-1:0] reg0, reg1;
  logic          ba, s0, s1;

  assign p0i = (ns_q << 1) & mask;
  assign p0a = (nsa_q << 1) & mask;
  assign p0s = (st_q << 1) & mask;
  assign head_n = (head_q == DW'(de - FW'(1))) ? '0 : head_q + DW'(1);
  assign idx_n  = (idx_q == '0) ? DW'(de - FW'(1)) : idx_q - DW'(1);

  always_comb begin
    d0 = rd0_q - best_q;
    d1 = rd1_q - best_q;
    if (prior_q) begin
      eff0 = (p0a == '0) ? '0 : Floor;
      eff1 = Floor;
    end else begin
      eff0 = (d0 < Floor) ? Floor : d0;
      eff1 = (d1 < Floor) ? Floor : d1;
    end
    ba   = 1'((nsa_q >> bsh));
    reg0 = RW'(p0a) | (RW'(ba) << (ke - 4'd1));
    reg1 = reg0 | RW'(1);
    bm0  = '0;
    bm1  = '0;
    for (int j = 0; j < 4; j++) begin
      s0 = (^(reg0 & RW'(poly_q[j]))) ^ inv_q[j];
      s1 = (^(reg1 & RW'(poly_q[j]))) ^ inv_q[j];
      if (3'(j) < ne) begin
        bm0 = s0 ? bm0 - llr_q[j] : bm0 + llr_q[j];
        bm1 = s1 ? bm1 - llr_q[j] : bm1 + llr_q[j];
      end
    end
    m0 = eff0 + bm0;
    m1 = eff1 + bm1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acs_step) begin
      rd0_q <= pm_mem[{bank_q, p0i}];
      rd1_q <= pm_mem[{bank_q, p0i | SW'(1)}];
    end
    if (vb_q) pm_mem[{~bank_q, nsb_q}] <= mb_q;
    if (cmd_i.commit) ring_mem[head_q] <= row_q;
    if (cmd_i.tb_step) rrow_q <= ring_mem[idx_n];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int j = 0; j < 4; j++)
        llr_q[j] <= XW'($signed(llr_i[j*LW +: LW]));
    end
    if (cmd_i.acs_step) nsa_q <= ns_q;
    if (va_q) begin
      nsb_q  <= nsa_q;
      tbit_q <= m1 > m0;
      mb_q   <= (m1 > m0) ? m1 : m0;
    end
    if (vb_q) begin
      row_q[nsb_q] <= tbit_q;
      if (nsb_q == '0 || mb_q > bestn_q) begin
        bestn_q <= mb_q;
        barg_q  <= nsb_q;
      end
    end
    if (cmd_i.commit) best_q <= bestn_q;
    if (cmd_i.commit) st_q <= barg_q;
    else if (rv_q) st_q <= rrow_q[st_q] ? (p0s | SW'(1)) : p0s;
    if (cmd_i.emit) outb_q <= 1'((st_q >> bsh));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= 1'b1;
      bank_q  <= 1'b0;
      head_q  <= '0;
      fill_q  <= '0;
      idx_q   <= '0;
      tcnt_q  <= '0;
      ns_q    <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      rv_q    <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      va_q <= cmd_i.acs_step;
      vb_q <= va_q;
      rv_q <= cmd_i.tb_step;
      if (cmd_i.restart || cfg_we_i) begin
        prior_q <= 1'b1;
        head_q  <= '0;
        fill_q  <= '0;
      end else if (cmd_i.commit) begin
        prior_q <= 1'b0;
        bank_q  <= ~bank_q;
        head_q  <= head_n;
        idx_q   <= head_n;
        tcnt_q  <= '0;
        if (fill_q < de) fill_q <= fill_q + FW'(1);
      end else if (cmd_i.tb_step) begin
        idx_q  <= idx_n;
        tcnt_q <= tcnt_q + FW'(1);
      end
      if (cmd_i.load) ns_q <= '0;
      else if (cmd_i.acs_step) ns_q <= ns_q + SW'(1);
      if (cmd_i.emit) outv_q <= 1'b1;
      else if (m_tready_i) outv_q <= 1'b0;
    end
  end

  assign sts_o.acs_last  = (ns_q == mask);
  assign sts_o.tb_last   = (tcnt_q == de - FW'(2));
  assign sts_o.full_next = (fill_q >= de - FW'(1));
  assign sts_o.depth_one = (de == FW'(1));
  assign sts_o.out_free  = !outv_q || m_tready_i;
  assign m_tvalid_o = outv_q;
  assign bit_o      = outb_q;
endmodule
`default_nettype wire

// File: hw/rtl/svd_ctrl.sv
// controller: sequences acs, commit, traceback and result hand-off per word
`default_nettype none
module svd_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_cmd_i,
  output logic               in_ready_o,
  input  svd_pkg::svd_sts_t  sts_i,
  output svd_pkg::svd_cmd_t  cmd_o
);
  import svd_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StAcs    = 3'd1;
  localparam logic [2:0] StDrain1 = 3'd2;
  localparam logic [2:0] StDrain2 = 3'd3;
  localparam logic [2:0] StCommit = 3'd4;
  localparam logic [2:0] StTb     = 3'd5;
  localparam logic [2:0] StTail   = 3'd6;
  localparam logic [2:0] StEmit   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_cmd_i == CmdRestart) begin
            cmd_o.restart = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = StAcs;
          end
        end
      end
      StAcs: begin
        cmd_o.acs_step = 1'b1;
        if (sts_i.acs_last) state_d = StDrain1;
      end
      StDrain1: state_d = StDrain2;
      StDrain2: state_d = StCommit;
      StCommit: begin
        cmd_o.commit = 1'b1;
        priority if (!sts_i.full_next) state_d = StIdle;
        else if (sts_i.depth_one) state_d = StEmit;
        else state_d = StTb;
      end
      StTb: begin
        cmd_o.tb_step = 1'b1;
        if (sts_i.tb_last) state_d = StTail;
      end
      StTail: state_d = StEmit;
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/soft_viterbi_decoder.sv
// Soft-decision Viterbi decoder, one trellis step per input word. A decode
// word runs the serial add-compare-select (one state per cycle through a
// dual-read metric memory) and, once the traceback window is full, a
// traceback (one decision-ring row read per cycle for trace_depth - 1 rows,
// then a tail state to settle the state) plus the hand-off of the result
// to the output register. The hand-off waits while the output register
// still holds an unaccepted word. A restart word keeps the controller idle.
// Reset needs no clearing pass: the all-zero prior is a flag and traceback
// only reads ring rows written since the last restart. Any configuration
// write restarts the decoder.
`default_nettype none
module soft_viterbi_decoder #(
  parameter int unsigned MAX_CONSTRAINT = svd_pkg::MaxConstraintDef,
  parameter int unsigned MAX_DEPTH      = svd_pkg::MaxDepthDef,
  parameter int unsigned LLR_WIDTH      = svd_pkg::LlrWidthDef,
  parameter int unsigned METRIC_WIDTH   = svd_pkg::MetricWidthDef,
  localparam int unsigned TDATA_W       = ((1 + 4 * LLR_WIDTH + 7) / 8) * 8
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_tvalid_i,
  output logic                        s_tready_o,
  input  wire [TDATA_W-1:0]           s_tdata_i,  // cmd, llr_a, llr_b, llr_c, llr_d
  output logic                        m_tvalid_o,
  input  wire                         m_tready_i,
  output logic [7:0]                  m_tdata_o,  // decoded_bit
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [svd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [svd_pkg::CfgDataW-1:0] cfg_data_i
);
  import svd_pkg::*;

  svd_cmd_t cmd;
  svd_sts_t sts;
  logic     dec_bit;

  assign cfg_ready_o = 1'b1;
  assign m_tdata_o   = {7'd0, dec_bit};

  svd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_cmd_i   (s_tdata_i[0]),
    .in_ready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  svd_dp #(
    .MAX_CONSTRAINT (MAX_CONSTRAINT),
    .MAX_DEPTH      (MAX_DEPTH),
    .LLR_WIDTH      (LLR_WIDTH),
    .METRIC_WIDTH   (METRIC_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .llr_i       (s_tdata_i[4*LLR_WIDTH:1]),
    .m_tready_i  (m_tready_i),
    .m_tvalid_o  (m_tvalid_o),
    .bit_o       (dec_bit)
  );
endmodule
`default_nettype wire

// File: hw/rtl/svd_chk.sv
// port-level checker for the soft viterbi decoder, bound to the top level
`default_nettype none
`include "soft_viterbi_decoder_defines.svh"
module svd_chk #(
  parameter int unsigned TDATA_W = 40
) (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               s_tvalid_i,
  input wire               s_tready_o,
  input wire [TDATA_W-1:0] s_tdata_i,
  input wire               m_tvalid_o,
  input wire               m_tready_i,
  input wire [7:0]         m_tdata_o
);
  import svd_pkg::*;

  `SVD_ASSERT_NXT(a_out_hold, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o))
  `SVD_ASSERT_NXT(a_busy_after_decode, s_tvalid_i && s_tready_o && s_tdata_i[0] == CmdDecode, !s_tready_o)
  `SVD_ASSERT_NXT(a_ready_after_restart, s_tvalid_i && s_tready_o && s_tdata_i[0] == CmdRestart, s_tready_o)
  `SVD_ASSERT_IMP(a_pad_zero, m_tvalid_o, m_tdata_o[7:1] == 7'd0)
endmodule

bind soft_viterbi_decoder svd_chk #(.TDATA_W(TDATA_W)) u_svd_chk (.*);
`default_nettype wire

// File: tb/soft_viterbi_decoder_tb.sv
// testbench of the soft viterbi decoder: coded streams checked against a trellis predictor
`default_nettype none
module soft_viterbi_decoder_tb;
  import svd_pkg::*;

  localparam int unsigned TdataW     = 40;
  localparam int          MetricFloor = -16384;
  localparam int          TailCycles = 200;
  localparam int          CycleLimit = 1000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [TdataW-1:0]   s_tdata_i = '0;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [7:0]          m_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  soft_viterbi_decoder i_dut (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // decoder mirror
  logic [6:0] reg_val [8];
  int         path_metric [64];
  bit         decisions [64][64];
  int         head, fill;
  bit         decoded_q [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_on = 1'b0;
  logic [6:0] enc_state = '0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void restart_trellis();
    for (int s = 0; s < 64; s++) begin
      path_metric[s] = MetricFloor;
      for (int r = 0; r < 64; r++) decisions[r][s] = 1'b0;
    end
    path_metric[0] = 0;
    head = 0;
    fill = 0;
  endfunction

  function automatic int active_k();
    int k;
    k = reg_val[CfgConstraint];
    if (k < 3) k = 3;
    if (k > 7) k = 7;
    return k;
  endfunction

  function automatic int active_n();
    int n;
    n = reg_val[CfgRate];
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    return n;
  endfunction

  function automatic int active_depth();
    int d;
    d = reg_val[CfgDepth];
    if (d < 1) d = 1;
    if (d > 64) d = 64;
    return d;
  endfunction

  function automatic int code_symbols(input int k, input int n, input int p, input int b);
    logic [6:0] sr;
    int w;
    sr = 7'((b << (k - 1)) | p);
    w = 0;
    for (int j = 0; j < n; j++)
      w |= int'((^(sr & reg_val[CfgPolyA + j])) ^ reg_val[CfgInvert][j]) << j;
    return w;
  endfunction

  function automatic void predict_step(input logic signed [7:0] la, lb, lc, ld);
    int k, n, dep, nstates, mask, best, barg, b, p0, p1, m0, m1, v, idx, st;
    int llr [4];
    int bm [16];
    int nxt [64];
    k = active_k();
    n = active_n();
    dep = active_depth();
    nstates = 1 << (k - 1);
    mask = nstates - 1;
    llr[0] = la; llr[1] = lb; llr[2] = lc; llr[3] = ld;
    for (int p = 0; p < (1 << n); p++) begin
      bm[p] = 0;
      for (int j = 0; j < n; j++) bm[p] += ((p >> j) & 1) ? -llr[j] : llr[j];
    end
    if (head >= dep) head = 0;
    best = 0;
    barg = 0;
    for (int ns = 0; ns < nstates; ns++) begin
      b = (ns >> (k - 2)) & 1;
      p0 = (ns << 1) & mask;
      p1 = p0 | 1;
      m0 = path_metric[p0] + bm[code_symbols(k, n, p0, b)];
      m1 = path_metric[p1] + bm[code_symbols(k, n, p1, b)];
      decisions[head][ns] = m1 > m0;
      nxt[ns] = (m1 > m0) ? m1 : m0;
      if (ns == 0 || nxt[ns] > best) begin
        best = nxt[ns];
        barg = ns;
      end
    end
    for (int ns = 0; ns < nstates; ns++) begin
      v = nxt[ns] - best;
      path_metric[ns] = (v < MetricFloor) ? MetricFloor : v;
    end
    head = (head + 1 >= dep) ? 0 : head + 1;
    if (fill < dep) fill++;
    if (fill < dep) return;
    idx = head;
    st = barg;
    for (int i = 0; i + 1 < dep; i++) begin
      idx = (idx == 0) ? dep - 1 : idx - 1;
      p0 = (st << 1) & mask;
      st = decisions[idx][st & mask] ? (p0 | 1) : p0;
    end
    decoded_q.push_back(bit'((st >> (k - 2)) & 1));
  endfunction

  task automatic send_word(input logic cmd, input logic signed [7:0] la, lb, lc, ld);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {7'b0, ld, lc, lb, la, cmd};
    do @(posedge clk_i); while (!s_tready_o);
    if (cmd == CmdRestart) begin
      restart_trellis();
      enc_state = '0;
    end else begin
      predict_step(la, lb, lc, ld);
    end
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_val[idx] = val;
    restart_trellis();
    enc_state = '0;
  endtask

  task automatic set_code(input int k, n, pa, pb, pc, pd, inv, dep);
    drain();
    write_reg(CfgConstraint, 7'(k));
    write_reg(CfgRate, 7'(n));
    write_reg(CfgPolyA, 7'(pa));
    write_reg(CfgPolyB, 7'(pb));
    write_reg(CfgPolyC, 7'(pc));
    write_reg(CfgPolyD, 7'(pd));
    write_reg(CfgInvert, 7'(inv));
    write_reg(CfgDepth, 7'(dep));
  endtask

  function automatic logic signed [7:0] noisy(input bit sym, input int mag);
    int v;
    v = (sym ? -mag : mag) + int'($urandom_range(80)) - 40;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return 8'(v);
  endfunction

  // coded stream with noise, plus some junk words and restarts
  task automatic send_coded(input int count);
    int k, n, b, w;
    logic [6:0] sr;
    logic signed [7:0] l [4];
    k = active_k();
    n = active_n();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        send_word(CmdRestart, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if ($urandom_range(99) < 10) begin
        send_word(CmdDecode, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        b = $urandom_range(1);
        sr = 7'((b << (k - 1)) | enc_state);
        w = code_symbols(k, n, int'(enc_state), b);
        enc_state = (sr >> 1) & 7'((1 << (k - 1)) - 1);
        for (int j = 0; j < 4; j++)
          l[j] = (j < n) ? noisy(w[j], $urandom_range(127)) : 8'($urandom);
        send_word(CmdDecode, l[0], l[1], l[2], l[3]);
      end
    end
  endtask

  task automatic random_code();
    set_code($urandom_range(3, 7), $urandom_range(1, 4), $urandom_range(127),
             $urandom_range(127), $urandom_range(127), $urandom_range(127),
             $urandom_range(15), ($urandom_range(3) == 0) ? $urandom_range(64)
                                                          : $urandom_range(1, 12));
  endtask

  task automatic test_directed_extremes();
    set_code(3, 1, 7, 5, 0, 0, 0, 1);
    send_word(CmdDecode, 8'sd127, 8'sd0, 8'sd0, 8'sd0);
    send_word(CmdDecode, -8'sd128, 8'sd0, 8'sd0, 8'sd0);
    send_word(CmdDecode, 8'sd0, 8'sd0, 8'sd0, 8'sd0);
    send_word(CmdRestart, 8'sd0, 8'sd0, 8'sd0, 8'sd0);
    send_word(CmdDecode, -8'sd1, 8'sd1, 8'sd0, 8'sd0);
    set_code(7, 4, 127, 121, 91, 1, 15, 64);
    for (int i = 0; i < 8; i++)
      send_word(CmdDecode, -8'sd128, 8'sd127, -8'sd128, 8'sd127);
    send_word(CmdRestart, -8'sd1, -8'sd1, -8'sd1, -8'sd1);
  endtask

  task automatic test_clamped_settings();
    // out-of-range k, rate and depth clamp or saturate
    set_code(0, 0, 3, 1, 2, 6, 5, 0);
    send_coded(6);
    set_code(7, 7, 121, 91, 101, 77, 10, 127);
    send_coded(12);
  endtask

  task automatic test_default_settings();
    drain();
    send_coded(70);
  endtask

  task automatic test_idle_phases();
    int pct [4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{29, 29}};
    for (int ph = 0; ph < 4; ph++) begin
      for (int c = 0; c < 3; c++) begin
        random_code();
        send_idle_pct = pct[ph][0];
        recv_stall_pct = pct[ph][1];
        send_coded(45);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    set_code(3, 2, 7, 5, 0, 0, 0, 1);
    @(posedge clk_i);
    // long receiver hold-off counted in its own process
    fork
      begin
        hold_on <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    send_coded(20);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (m_tvalid_o && m_tready_i) begin
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected word %0d", m_tdata_o[0]));
      end else if (m_tdata_o[0] !== decoded_q[0]) begin
        report($sformatf("decoded_bit %0d, expected %0d", m_tdata_o[0], decoded_q[0]));
        void'(decoded_q.pop_front());
      end else begin
        void'(decoded_q.pop_front());
      end
    end
    if (hold_on) begin
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("soft_viterbi_decoder test failed");
      $finish;
    end
  end

  initial begin
    reg_val[CfgConstraint] = 7; reg_val[CfgRate] = 2;
    reg_val[CfgPolyA] = 121; reg_val[CfgPolyB] = 91;
    reg_val[CfgPolyC] = 0; reg_val[CfgPolyD] = 0;
    reg_val[CfgInvert] = 0; reg_val[CfgDepth] = 60;
    restart_trellis();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_settings();
    test_directed_extremes();
    test_clamped_settings();
    test_output_backpressure();
    test_idle_phases();
    drain();
    if (errors == 0) begin
      $display("soft_viterbi_decoder test passed");
    end else begin
      $display("soft_viterbi_decoder test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/svd_pkg.sv
hw/rtl/svd_dp.sv
hw/rtl/svd_ctrl.sv
hw/rtl/soft_viterbi_decoder.sv
hw/rtl/svd_chk.sv
tb/soft_viterbi_decoder_tb.sv
